@@ hw/rtl/pmr_pkg.sv @@
// shared types, constants and widths for the pixel map rotate block
package pmr_pkg;

  localparam int unsigned SRC_DEPTH     = 65536;
  localparam int unsigned SRC_AW        = $clog2(SRC_DEPTH);
  localparam int unsigned FRACTION_BITS = 10;
  localparam int unsigned COORD_BITS    = 12;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LOAD_IDX_W = 16;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned TRIG_W     = 12;
  localparam int unsigned CENTRE_W   = 12;
  localparam int unsigned KEY_W      = 9;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned COS_ONE    = 1 << FRACTION_BITS;

  localparam int unsigned IN_FIELD_W = LOAD_IDX_W + PIX_W + 2 * COORD_BITS;
  localparam int unsigned IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((PIX_W + 7) / 8) * 8;

  localparam int unsigned IN_PIX_LSB = LOAD_IDX_W;
  localparam int unsigned IN_DX_LSB  = LOAD_IDX_W + PIX_W;
  localparam int unsigned IN_DY_LSB  = LOAD_IDX_W + PIX_W + COORD_BITS;

  // datapath widths
  localparam int unsigned DIFF_W = ((COORD_BITS > CENTRE_W) ? COORD_BITS : CENTRE_W) + 2;
  localparam int unsigned PROD_W = DIFF_W + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned HC_W   = SIZE_W + 2;
  localparam int unsigned POS_W  =
    ((SUM_W - FRACTION_BITS > DIFF_W) ? SUM_W - FRACTION_BITS : DIFF_W) + 1;
  localparam int unsigned ROWP_W = 2 * SIZE_W;
  localparam int unsigned ADDR_W = (SRC_AW + 1 > ROWP_W + 1) ? SRC_AW + 1 : ROWP_W + 1;

  typedef enum logic [1:0] {
    ROT_GENERAL,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAW_MODE,
    REG_COS_VALUE,
    REG_SIN_VALUE,
    REG_SRC_COLS,
    REG_SRC_ROWS,
    REG_CENTRE_OUT_X,
    REG_CENTRE_OUT_Y,
    REG_TRANSPARENT_KEY
  } cfg_idx_e;

  typedef struct packed {
    rot_e                        rot;
    logic                        cw;
    logic signed [TRIG_W-1:0]    cos_value;
    logic signed [TRIG_W-1:0]    sin_value;
    logic [SIZE_W-1:0]           src_cols;
    logic [SIZE_W-1:0]           src_rows;
    logic signed [CENTRE_W-1:0]  centre_out_x;
    logic signed [CENTRE_W-1:0]  centre_out_y;
    logic signed [KEY_W-1:0]     transparent_key;
  } cfg_t;

  // memory access issued by the address pipeline
  typedef struct packed {
    logic              valid;
    logic              draw;
    logic              hit;
    logic              we;
    logic [SRC_AW-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } req_t;

endpackage

@@ hw/rtl/pmr_ram.sv @@
// generic single port ram with registered read
module pmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pmr_addr.sv @@
// address pipeline: recentre, rotate, bounds check and source address
module pmr_addr (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  pmr_pkg::cfg_t                         cfg_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_draw_i,
  input  logic [pmr_pkg::LOAD_IDX_W-1:0]        load_index_i,
  input  logic [pmr_pkg::PIX_W-1:0]             load_pixel_i,
  input  logic signed [pmr_pkg::COORD_BITS-1:0] dest_x_i,
  input  logic signed [pmr_pkg::COORD_BITS-1:0] dest_y_i,
  output pmr_pkg::req_t                         req_o
);

  localparam int unsigned DW = pmr_pkg::DIFF_W;
  localparam int unsigned PW = pmr_pkg::PROD_W;
  localparam int unsigned SW = pmr_pkg::SUM_W;
  localparam int unsigned HW = pmr_pkg::HC_W;
  localparam int unsigned QW = pmr_pkg::POS_W;
  localparam int unsigned RW = pmr_pkg::ROWP_W;
  localparam int unsigned AW = pmr_pkg::ADDR_W;
  localparam int unsigned NW = pmr_pkg::SIZE_W;

  // stage a: recentred or directly flipped coordinates
  logic                              a_valid_q, a_draw_q;
  logic [pmr_pkg::LOAD_IDX_W-1:0]    a_idx_q;
  logic [pmr_pkg::PIX_W-1:0]         a_pix_q;
  logic signed [DW-1:0]              a_x_d, a_y_d, a_x_q, a_y_q;

  always_comb begin
    a_x_d = DW'(dest_x_i) - DW'(cfg_i.centre_out_x);
    a_y_d = DW'(dest_y_i) - DW'(cfg_i.centre_out_y);
    unique case (cfg_i.rot)
      pmr_pkg::ROT_GENERAL: begin
      end
      pmr_pkg::ROT_90: begin
        a_x_d = DW'(dest_y_i);
        a_y_d = DW'(cfg_i.src_rows) - DW'(1) - DW'(dest_x_i);
      end
      pmr_pkg::ROT_180: begin
        a_x_d = DW'(cfg_i.src_cols) - DW'(1) - DW'(dest_x_i);
        a_y_d = DW'(cfg_i.src_rows) - DW'(1) - DW'(dest_y_i);
      end
      pmr_pkg::ROT_270: begin
        a_x_d = DW'(cfg_i.src_cols) - DW'(1) - DW'(dest_y_i);
        a_y_d = DW'(dest_x_i);
      end
      default: begin
      end
    endcase
  end

  // stage b: four rotation products
  logic                              b_valid_q, b_draw_q;
  logic [pmr_pkg::LOAD_IDX_W-1:0]    b_idx_q;
  logic [pmr_pkg::PIX_W-1:0]         b_pix_q;
  logic signed [DW-1:0]              b_x_q, b_y_q;
  logic signed [PW-1:0]              b_xc_d, b_ys_d, b_yc_d, b_xs_d;
  logic signed [PW-1:0]              b_xc_q, b_ys_q, b_yc_q, b_xs_q;

  always_comb begin
    b_xc_d = PW'(a_x_q) * PW'(cfg_i.cos_value);
    b_ys_d = PW'(a_y_q) * PW'(cfg_i.sin_value);
    b_yc_d = PW'(a_y_q) * PW'(cfg_i.cos_value);
    b_xs_d = PW'(a_x_q) * PW'(cfg_i.sin_value);
  end

  // stage c: source column and row
  logic                              c_valid_q, c_draw_q;
  logic [pmr_pkg::LOAD_IDX_W-1:0]    c_idx_q;
  logic [pmr_pkg::PIX_W-1:0]         c_pix_q;
  logic signed [SW-1:0]              sum_c, sum_r, sh_c, sh_r;
  logic [HW-1:0]                     half_c, half_r;
  logic signed [HW-1:0]              hc, hr;
  logic signed [QW-1:0]              c_col_d, c_row_d, c_col_q, c_row_q;

  always_comb begin
    sum_c  = SW'(b_xc_q) + SW'(b_ys_q);
    sum_r  = SW'(b_yc_q) - SW'(b_xs_q);
    sh_c   = sum_c >>> pmr_pkg::FRACTION_BITS;
    sh_r   = sum_r >>> pmr_pkg::FRACTION_BITS;
    half_c = HW'(cfg_i.src_cols >> 1);
    half_r = HW'(cfg_i.src_rows >> 1);
    if (cfg_i.cw) begin
      hc = half_c;
      hr = HW'(cfg_i.src_rows) - HW'(1) - half_r;
    end else begin
      hc = HW'(cfg_i.src_cols) - HW'(1) - half_c;
      hr = half_r;
    end
    if (cfg_i.rot == pmr_pkg::ROT_GENERAL) begin
      c_col_d = QW'(sh_c) + QW'(hc);
      c_row_d = QW'(sh_r) + QW'(hr);
    end else begin
      c_col_d = QW'(b_x_q);
      c_row_d = QW'(b_y_q);
    end
  end

  // stage d: bounds check and row offset
  logic                              d_valid_q, d_draw_q;
  logic [pmr_pkg::LOAD_IDX_W-1:0]    d_idx_q;
  logic [pmr_pkg::PIX_W-1:0]         d_pix_q;
  logic                              d_inr_d, d_inr_q;
  logic [RW-1:0]                     d_prod_d, d_prod_q;
  logic [NW-1:0]                     d_col_q;

  always_comb begin
    d_inr_d = !c_col_q[QW-1] && !c_row_q[QW-1]
              && ($unsigned(c_col_q) < QW'(cfg_i.src_cols))
              && ($unsigned(c_row_q) < QW'(cfg_i.src_rows));
    d_prod_d = RW'(c_row_q[NW-1:0]) * RW'(cfg_i.src_cols);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_draw_q <= in_draw_i;
      a_idx_q  <= load_index_i;
      a_pix_q  <= load_pixel_i;
      a_x_q    <= a_x_d;
      a_y_q    <= a_y_d;
      b_draw_q <= a_draw_q;
      b_idx_q  <= a_idx_q;
      b_pix_q  <= a_pix_q;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_xc_q   <= b_xc_d;
      b_ys_q   <= b_ys_d;
      b_yc_q   <= b_yc_d;
      b_xs_q   <= b_xs_d;
      c_draw_q <= b_draw_q;
      c_idx_q  <= b_idx_q;
      c_pix_q  <= b_pix_q;
      c_col_q  <= c_col_d;
      c_row_q  <= c_row_d;
      d_draw_q <= c_draw_q;
      d_idx_q  <= c_idx_q;
      d_pix_q  <= c_pix_q;
      d_inr_q  <= d_inr_d;
      d_prod_q <= d_prod_d;
      d_col_q  <= c_col_q[NW-1:0];
    end
  end

  // final address and memory request
  logic [AW-1:0] addr_sum, load_addr;

  always_comb begin
    addr_sum      = AW'(d_prod_q) + AW'(d_col_q);
    load_addr     = AW'(d_idx_q);
    req_o.valid   = d_valid_q;
    req_o.draw    = d_draw_q;
    req_o.hit     = d_inr_q && (addr_sum < AW'(pmr_pkg::SRC_DEPTH));
    req_o.we      = !d_draw_q && (load_addr < AW'(pmr_pkg::SRC_DEPTH));
    req_o.addr    = d_draw_q ? addr_sum[pmr_pkg::SRC_AW-1:0]
                             : load_addr[pmr_pkg::SRC_AW-1:0];
    req_o.wdata   = d_pix_q;
  end

endmodule

@@ hw/rtl/pmr_out.sv @@
// result stage: transparency test, output register and skid buffer
module pmr_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pmr_pkg::req_t                        req_i,
  input  logic [pmr_pkg::PIX_W-1:0]            rdata_i,
  input  logic signed [pmr_pkg::KEY_W-1:0]     key_i,
  output logic                                 en_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pmr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // pixel_value
  output logic [0:0]                           m_axis_tuser   // write_pixel
);

  logic                        f_valid_q, f_draw_q, f_hit_q;
  logic                        key_hit, res_valid, res_wr;
  logic [pmr_pkg::PIX_W-1:0]   res_pix;
  logic                        out_valid_d, out_valid_q, out_wr_d, out_wr_q;
  logic [pmr_pkg::PIX_W-1:0]   out_pix_d, out_pix_q;
  logic                        skid_valid_d, skid_valid_q, skid_wr_d, skid_wr_q;
  logic [pmr_pkg::PIX_W-1:0]   skid_pix_d, skid_pix_q;

  assign en_o = !skid_valid_q;

  always_comb begin
    key_hit   = !key_i[pmr_pkg::KEY_W-1] && (key_i[pmr_pkg::PIX_W-1:0] == rdata_i);
    res_wr    = f_draw_q && f_hit_q && !key_hit;
    res_pix   = res_wr ? rdata_i : '0;
    res_valid = f_valid_q && en_o;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_wr_d     = out_wr_q;
    out_pix_d    = out_pix_q;
    skid_valid_d = skid_valid_q;
    skid_wr_d    = skid_wr_q;
    skid_pix_d   = skid_pix_q;
    if (m_axis_tready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_wr_d     = skid_wr_q;
        out_pix_d    = skid_pix_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_wr_d    = res_wr;
        out_pix_d   = res_pix;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_wr_d    = res_wr;
      skid_pix_d   = res_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en_o) begin
        f_valid_q <= req_i.valid;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      f_draw_q <= req_i.draw;
      f_hit_q  <= req_i.hit;
    end
    out_wr_q   <= out_wr_d;
    out_pix_q  <= out_pix_d;
    skid_wr_q  <= skid_wr_d;
    skid_pix_q <= skid_pix_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pmr_pkg::OUT_DATA_W'(out_pix_q);
  assign m_axis_tuser  = out_wr_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_wr_q) |-> (out_pix_q == '0))
    else $error("pixel value nonzero on a result that writes nothing");

endmodule

@@ hw/rtl/pixelmap_rotate_8bpp.sv @@
// top level of the nearest neighbour rotating pixel mapper
//
//   channel  direction  handshake                    payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tuser: mode, tdata: load/draw fields
//   m_axis   out        m_axis_tvalid/m_axis_tready  tuser: write_pixel, tdata: pixel_value
//   cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one item per cycle while s_axis_tready is high; a result reaches m_axis through
// four address stages, the source memory read and the output register
// the single port source memory takes one load write or one draw read per cycle while s_axis_tready is high
// reset clears control and configuration only; the source memory is not cleared
// a stalled output fills a register and a skid entry, then s_axis_tready drops
module pixelmap_rotate_8bpp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // load_index, load_pixel, dest_x, dest_y
  input  logic [pmr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_value
  output logic [pmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // write_pixel
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pmr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  pmr_pkg::cfg_t                cfg_q;
  pmr_pkg::req_t                req;
  logic                         en;
  logic [pmr_pkg::PIX_W-1:0]    rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot             <= pmr_pkg::ROT_GENERAL;
      cfg_q.cw              <= 1'b0;
      cfg_q.cos_value       <= pmr_pkg::TRIG_W'(pmr_pkg::COS_ONE);
      cfg_q.sin_value       <= '0;
      cfg_q.src_cols        <= pmr_pkg::SIZE_W'(1);
      cfg_q.src_rows        <= pmr_pkg::SIZE_W'(1);
      cfg_q.centre_out_x    <= '0;
      cfg_q.centre_out_y    <= '0;
      cfg_q.transparent_key <= '1;
    end else if (cfg_valid_i) begin
      unique case (pmr_pkg::cfg_idx_e'(cfg_index_i))
        pmr_pkg::REG_DRAW_MODE: begin
          cfg_q.rot <= pmr_pkg::rot_e'(cfg_data_i[1:0]);
          cfg_q.cw  <= cfg_data_i[2];
        end
        pmr_pkg::REG_COS_VALUE:       cfg_q.cos_value <= cfg_data_i[pmr_pkg::TRIG_W-1:0];
        pmr_pkg::REG_SIN_VALUE:       cfg_q.sin_value <= cfg_data_i[pmr_pkg::TRIG_W-1:0];
        pmr_pkg::REG_SRC_COLS:        cfg_q.src_cols  <= cfg_data_i[pmr_pkg::SIZE_W-1:0];
        pmr_pkg::REG_SRC_ROWS:        cfg_q.src_rows  <= cfg_data_i[pmr_pkg::SIZE_W-1:0];
        pmr_pkg::REG_CENTRE_OUT_X:
          cfg_q.centre_out_x <= cfg_data_i[pmr_pkg::CENTRE_W-1:0];
        pmr_pkg::REG_CENTRE_OUT_Y:
          cfg_q.centre_out_y <= cfg_data_i[pmr_pkg::CENTRE_W-1:0];
        pmr_pkg::REG_TRANSPARENT_KEY:
          cfg_q.transparent_key <= cfg_data_i[pmr_pkg::KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = en;

  pmr_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_draw_i    (s_axis_tuser[0]),
    .load_index_i (s_axis_tdata[pmr_pkg::LOAD_IDX_W-1:0]),
    .load_pixel_i (s_axis_tdata[pmr_pkg::IN_PIX_LSB +: pmr_pkg::PIX_W]),
    .dest_x_i     (s_axis_tdata[pmr_pkg::IN_DX_LSB +: pmr_pkg::COORD_BITS]),
    .dest_y_i     (s_axis_tdata[pmr_pkg::IN_DY_LSB +: pmr_pkg::COORD_BITS]),
    .req_o        (req)
  );

  pmr_ram #(
    .WIDTH (pmr_pkg::PIX_W),
    .DEPTH (pmr_pkg::SRC_DEPTH)
  ) u_src_ram (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (req.valid && req.we),
    .addr_i  (req.addr),
    .wdata_i (req.wdata),
    .rdata_o (rdata)
  );

  pmr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .rdata_i       (rdata),
    .key_i         (cfg_q.transparent_key),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ tb/sv/pmr_tb_pkg.sv @@
// register decode and source lookup geometry shared by the pixel mapper stimulus and checker
package pmr_tb_pkg;
  import pmr_pkg::*;

  localparam int unsigned CFG_REG_COUNT = 8;
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_DRAW = 1'b1;

  function automatic cfg_t cfg_at_reset();
    cfg_t c;
    c = '0;
    c.rot = ROT_GENERAL;
    c.cos_value = TRIG_W'(COS_ONE);
    c.src_cols = SIZE_W'(1);
    c.src_rows = SIZE_W'(1);
    c.transparent_key = '1;
    return c;
  endfunction

  function automatic cfg_t cfg_apply(input cfg_t c, input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] d);
    cfg_t n;
    n = c;
    case (idx)
      REG_DRAW_MODE: begin
        n.rot = rot_e'(d[1:0]);
        n.cw  = d[2];
      end
      REG_COS_VALUE:       n.cos_value = d[TRIG_W-1:0];
      REG_SIN_VALUE:       n.sin_value = d[TRIG_W-1:0];
      REG_SRC_COLS:        n.src_cols = d[SIZE_W-1:0];
      REG_SRC_ROWS:        n.src_rows = d[SIZE_W-1:0];
      REG_CENTRE_OUT_X:    n.centre_out_x = d[CENTRE_W-1:0];
      REG_CENTRE_OUT_Y:    n.centre_out_y = d[CENTRE_W-1:0];
      REG_TRANSPARENT_KEY: n.transparent_key = d[KEY_W-1:0];
      default: ;
    endcase
    return n;
  endfunction

  // maps a destination coordinate back to a source store address; 0 on a miss
  function automatic bit src_lookup(input cfg_t c, input logic [COORD_BITS-1:0] x,
                                    input logic [COORD_BITS-1:0] y,
                                    output int unsigned addr);
    longint cols, rows, dx, dy, col, row, hc, hr, cosv, sinv, a;
    cols = longint'(c.src_cols);
    rows = longint'(c.src_rows);
    dx = longint'($signed(x));
    dy = longint'($signed(y));
    addr = 0;
    case (c.rot)
      ROT_90: begin
        col = dy;
        row = rows - 1 - dx;
      end
      ROT_180: begin
        col = cols - 1 - dx;
        row = rows - 1 - dy;
      end
      ROT_270: begin
        col = cols - 1 - dy;
        row = dx;
      end
      default: begin
        hc = cols >>> 1;
        hr = rows >>> 1;
        // screen orientation decides which centre rounds down
        if (c.cw) hr = rows - 1 - hr;
        else hc = cols - 1 - hc;
        cosv = longint'($signed(c.cos_value));
        sinv = longint'($signed(c.sin_value));
        dx = dx - longint'($signed(c.centre_out_x));
        dy = dy - longint'($signed(c.centre_out_y));
        col = ((dx * cosv + dy * sinv) >>> FRACTION_BITS) + hc;
        row = ((dy * cosv - dx * sinv) >>> FRACTION_BITS) + hr;
      end
    endcase
    if (col < 0 || col >= cols || row < 0 || row >= rows) return 1'b0;
    a = row * cols + col;
    if (a >= longint'(SRC_DEPTH)) return 1'b0;
    addr = 32'(a);
    return 1'b1;
  endfunction

endpackage

@@ tb/sv/pmr_checker.sv @@
// pixel mapper checker: tracks config and source store, predicts and compares each result
module pmr_checker
  import pmr_pkg::*;
  import pmr_tb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [0:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    writes_o
);

  typedef struct packed {
    logic             write_pixel;
    logic [PIX_W-1:0] pixel_value;
  } pix_result_t;

  cfg_t             cfg_q;
  logic [PIX_W-1:0] src_store [SRC_DEPTH];
  pix_result_t      pixel_exp_q [$];

  task automatic flag_pixel(input string what, input pix_result_t want, input pix_result_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("mismatch (%s): expected write_pixel=%0d pixel_value=%02h, got %0d/%02h",
               what, want.write_pixel, want.pixel_value, got.write_pixel, got.pixel_value);
    end
  endtask

  always @(posedge clk_i) begin : watch
    pix_result_t want, got;
    logic [COORD_BITS-1:0] dx, dy;
    int unsigned addr;
    logic [PIX_W-1:0] pix;
    if (!rst_ni) begin
      cfg_q = cfg_at_reset();
      pixel_exp_q.delete();
      fail_count_o = 0;
      results_o = 0;
      writes_o = 0;
    end else begin
      // output side first so a result never meets an expectation from the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_pixel = m_axis_tuser[0];
        got.pixel_value = m_axis_tdata[PIX_W-1:0];
        results_o++;
        if (got.write_pixel === 1'b1) writes_o++;
        if (pixel_exp_q.size() == 0) begin
          flag_pixel("nothing pending", '0, got);
        end else begin
          want = pixel_exp_q.pop_front();
          if (got.write_pixel !== want.write_pixel || got.pixel_value !== want.pixel_value)
            flag_pixel("field", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = '0;
        if (s_axis_tuser[0] == ITEM_LOAD) begin
          src_store[s_axis_tdata[LOAD_IDX_W-1:0]] = s_axis_tdata[IN_PIX_LSB +: PIX_W];
        end else begin
          dx = s_axis_tdata[IN_DX_LSB +: COORD_BITS];
          dy = s_axis_tdata[IN_DY_LSB +: COORD_BITS];
          if (src_lookup(cfg_q, dx, dy, addr)) begin
            pix = src_store[addr];
            // a negative key never equals a pixel
            if (longint'($signed(cfg_q.transparent_key)) != longint'(pix)) begin
              want.write_pixel = 1'b1;
              want.pixel_value = pix;
            end
          end
        end
        pixel_exp_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_o) cfg_q = cfg_apply(cfg_q, cfg_index_i, cfg_data_i);
    end
    pending_o = pixel_exp_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// pixel mapper testbench top: clock, reset, stimulus, handshake pressure and verdict
module tb_top;
  import pmr_pkg::*;
  import pmr_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned HOLD_CYCLES    = 240;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned PHASE_COUNT    = 13;
  localparam int unsigned PHASE_ITEMS    = 58;
  localparam int unsigned PRESSURE_PHASE = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          fail_count, pending, results, writes;
  int unsigned send_idle_pct, recv_stall_pct, items_sent, quiet_cycles;
  bit          hold_req;
  cfg_t        drive_cfg;
  bit          loaded [SRC_DEPTH];

  pixelmap_rotate_8bpp dut (.*);

  pmr_checker u_checker (
    .*,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .writes_o     (writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_pixel_item(input logic [LOAD_IDX_W-1:0] idx, input logic [PIX_W-1:0] pix);
    loaded[idx] = 1'b1;
    send_item(ITEM_LOAD, IN_DATA_W'({12'($urandom()), 12'($urandom()), pix, idx}));
  endtask

  // a draw that would read a never loaded entry gets that entry loaded first
  task automatic draw_item(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    int unsigned addr;
    logic [PIX_W-1:0] pix;
    if (src_lookup(drive_cfg, x, y, addr) && !loaded[addr]) begin
      pix = 8'($urandom());
      if (!drive_cfg.transparent_key[KEY_W-1] && $urandom_range(3) == 0)
        pix = drive_cfg.transparent_key[PIX_W-1:0];
      load_pixel_item(addr[LOAD_IDX_W-1:0], pix);
    end
    send_item(ITEM_DRAW, IN_DATA_W'({y, x, 8'($urandom()), 16'($urandom())}));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    drive_cfg = cfg_apply(drive_cfg, idx, data);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pending != 0 || hold_req);
  endtask

  task automatic pick_setting(input int unsigned p);
    logic [CFG_DATA_W-1:0] junk;
    int mode, cols, rows, cosv, sinv, cx, cy, key;
    junk = 12'($urandom());
    mode = $urandom_range(7);
    if ($urandom_range(1) == 0) mode = mode & 4;
    cols = $urandom_range(1, 24);
    rows = $urandom_range(1, 24);
    cosv = int'($urandom_range(2048)) - 1024;
    sinv = int'($urandom_range(2048)) - 1024;
    cx = int'($urandom_range(80)) - 40;
    cy = int'($urandom_range(80)) - 40;
    key = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(255));
    case (p)
      0: mode = 0;
      1: begin
        mode = 4; cols = 256; rows = 256; cosv = -1024; sinv = 1024;
        cx = 1024; cy = -1024; key = 255;
      end
      2: begin
        mode = 0; cols = 1; rows = 256; cosv = 1024; sinv = -1024;
        cx = -1024; cy = 1024; key = 0;
      end
      3: begin
        mode = 1; cols = 256; rows = 1;
      end
      4: mode = 2;
      5: mode = 3;
      6: begin
        mode = 5; cols = 0; rows = 7;
      end
      7: begin
        mode = 6; cols = 300; rows = 511; key = -256;
      end
      8: begin
        mode = 7; cols = 9; rows = 0;
      end
      9: begin
        mode = 4; cosv = -2048; sinv = 2047; cx = -2048; cy = 2047;
      end
      10: begin
        mode = 0; cosv = 0; sinv = 0;
      end
      default: ;
    endcase
    write_reg(REG_DRAW_MODE, {junk[11:3], 3'(mode)});
    write_reg(REG_COS_VALUE, 12'(cosv));
    write_reg(REG_SIN_VALUE, 12'(sinv));
    write_reg(REG_SRC_COLS, {junk[11:9], 9'(cols)});
    write_reg(REG_SRC_ROWS, {junk[8:6], 9'(rows)});
    write_reg(REG_CENTRE_OUT_X, 12'(cx));
    write_reg(REG_CENTRE_OUT_Y, 12'(cy));
    write_reg(REG_TRANSPARENT_KEY, {junk[5:3], 9'(key)});
    // an index past the register list must leave the setting alone
    write_reg(CFG_IDX_W'(CFG_REG_COUNT + $urandom_range(7)), 12'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned r;
    int cols, rows, x, y, span, area;
    cols = int'(drive_cfg.src_cols);
    rows = int'(drive_cfg.src_rows);
    r = $urandom_range(99);
    if (r < 15) begin
      load_pixel_item(16'($urandom()), 8'($urandom()));
    end else if (r < 30) begin
      area = (cols * rows > 0) ? cols * rows : 1;
      if (area > 65536) area = 65536;
      load_pixel_item(16'($urandom_range(area - 1)), 8'($urandom()));
    end else if (r < 80) begin
      case (drive_cfg.rot)
        ROT_90, ROT_270: begin
          x = int'($urandom_range(rows + 1)) - 1;
          y = int'($urandom_range(cols + 1)) - 1;
        end
        ROT_180: begin
          x = int'($urandom_range(cols + 1)) - 1;
          y = int'($urandom_range(rows + 1)) - 1;
        end
        default: begin
          span = (cols + rows) / 2 + 2;
          x = int'($signed(drive_cfg.centre_out_x)) + int'($urandom_range(2 * span)) - span;
          y = int'($signed(drive_cfg.centre_out_y)) + int'($urandom_range(2 * span)) - span;
        end
      endcase
      draw_item(12'(x), 12'(y));
    end else begin
      draw_item(12'($urandom()), 12'($urandom()));
    end
  endtask

  initial begin : stimulus
    int unsigned p, i;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    items_sent     = 0;
    drive_cfg      = cfg_at_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: a one pixel image, field extremes and misses on every side
    load_pixel_item(16'h0000, 8'hAB);
    load_pixel_item(16'hFFFF, 8'hFF);
    load_pixel_item(16'h5555, 8'h00);
    load_pixel_item(16'hAAAA, 8'h55);
    draw_item(12'h000, 12'h000);
    draw_item(12'h800, 12'h800);
    draw_item(12'h7FF, 12'h7FF);
    draw_item(12'h800, 12'h7FF);
    draw_item(12'h7FF, 12'h800);
    draw_item(12'h001, 12'h000);
    draw_item(12'hFFF, 12'h000);
    draw_item(12'h000, 12'hFFF);
    s_axis_tvalid <= 1'b0;

    // key equal to the stored pixel, then a negative key with the same low bits
    wait_idle();
    write_reg(REG_TRANSPARENT_KEY, 12'h0AB);
    cfg_valid_i <= 1'b0;
    draw_item(12'h000, 12'h000);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_reg(REG_TRANSPARENT_KEY, 12'h1AB);
    cfg_valid_i <= 1'b0;
    draw_item(12'h000, 12'h000);
    s_axis_tvalid <= 1'b0;

    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      pick_setting(p);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
      s_axis_tvalid <= 1'b0;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run: %0d items over %0d register settings, all draw modes, long output hold-off",
             items_sent, PHASE_COUNT + 3);
    $display("run: %0d results checked, %0d pixel writes, %0d mismatches",
             results, writes, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
